>>> design/mgca_pkg.sv
package mgca_pkg;

    localparam int GEAR_COUNT = 6;
    localparam int CODE_W     = 3;
    localparam int TDATA_W    = 24;
    localparam int PAD_W      = TDATA_W - GEAR_COUNT * CODE_W;

    typedef logic [CODE_W-1:0] code_t;
    typedef code_t [GEAR_COUNT-1:0] code_vec_t;

    typedef enum logic [1:0] {
        MAP_A = 2'd0,
        MAP_B = 2'd1,
        MAP_C = 2'd2,
        MAP_D = 2'd3
    } map_sel_t;

    typedef struct packed {
        logic      half_flag;
        code_vec_t code;
    } gear_word_t;

    function automatic code_t remap(input map_sel_t sel, input code_t code);
        code_t res;
        res = code;
        case (sel)
            MAP_A: begin
                case (code)
                    3'd7:    res = 3'd5;
                    3'd4:    res = 3'd0;
                    3'd1:    res = 3'd3;
                    3'd2:    res = 3'd6;
                    default: res = code;
                endcase
            end
            MAP_B: begin
                case (code)
                    3'd5:    res = 3'd7;
                    3'd0:    res = 3'd4;
                    3'd3:    res = 3'd1;
                    3'd6:    res = 3'd2;
                    default: res = code;
                endcase
            end
            MAP_C: begin
                case (code)
                    3'd6:    res = 3'd7;
                    3'd5:    res = 3'd4;
                    3'd0:    res = 3'd1;
                    3'd3:    res = 3'd2;
                    default: res = code;
                endcase
            end
            MAP_D: begin
                case (code)
                    3'd7:    res = 3'd6;
                    3'd4:    res = 3'd5;
                    3'd1:    res = 3'd0;
                    3'd2:    res = 3'd3;
                    default: res = code;
                endcase
            end
            default: res = code;
        endcase
        return res;
    endfunction

    // middle stages pick their map by the pair the previous code falls in
    function automatic map_sel_t mid_sel(input code_t prev);
        map_sel_t sel;
        case (prev[2:1])
            2'd0:    sel = MAP_B;
            2'd1:    sel = MAP_A;
            2'd2:    sel = MAP_C;
            default: sel = MAP_D;
        endcase
        return sel;
    endfunction

    // last stage pairs: {0,4} B, {1,3} A, {2,6} D, {5,7} C
    function automatic map_sel_t last_sel(input code_t prev);
        map_sel_t sel;
        case (prev)
            3'd0, 3'd4: sel = MAP_B;
            3'd1, 3'd3: sel = MAP_A;
            3'd2, 3'd6: sel = MAP_D;
            default:    sel = MAP_C;
        endcase
        return sel;
    endfunction

endpackage

>>> design/mgca_remap.sv
module mgca_remap
    import mgca_pkg::*;
(
    input  gear_word_t raw,
    output code_vec_t  fixed
);

    always_comb begin
        fixed[0] = remap(raw.half_flag ? MAP_C : MAP_A, raw.code[0]);
        for (int g = 1; g < GEAR_COUNT - 1; g++) begin
            fixed[g] = remap(mid_sel(fixed[g-1]), raw.code[g]);
        end
        fixed[GEAR_COUNT-1] = remap(last_sel(fixed[GEAR_COUNT-2]),
                                    raw.code[GEAR_COUNT-1]);
    end

endmodule

>>> design/mgca_out_buf.sv
module mgca_out_buf
    import mgca_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load_valid,
    input  code_vec_t load_word,
    output logic      load_ready,
    output logic      out_valid,
    output code_vec_t out_word,
    input  logic      out_ready
);

    logic      valid_reg;
    logic      valid_next;
    code_vec_t word_reg;

    // take a new word whenever the held one is gone or leaves this cycle
    assign load_ready = !valid_reg || out_ready;
    assign valid_next = load_ready ? load_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ready && load_valid) begin
            word_reg <= load_word;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> design/multiturn_gear_code_align.sv
// Path: a word accepted on s_ passes through the input register and the remap chain,
// then appears on m_ from the result register.
// Throughput: one word per cycle; s_tready drops only while both registers hold
// words and m_tready is low.
// Reset: aresetn low clears both valid flags; payload registers are not reset.
module multiturn_gear_code_align
    import mgca_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,  // gear_code_0 .. gear_code_5, 3 bits each, zero pad
    input  logic               s_tuser,  // half_turn_flag
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata   // fixed_code_0 .. fixed_code_5, 3 bits each, zero pad
);

    logic       in_valid_reg;
    logic       in_valid_next;
    gear_word_t in_word_reg;
    gear_word_t in_word;
    code_vec_t  fixed;
    code_vec_t  out_word;
    logic       out_ready;

    assign in_word.half_flag = s_tuser;
    assign in_word.code      = s_tdata[GEAR_COUNT*CODE_W-1:0];

    // advance the input stage when empty or when the result stage takes it
    assign s_tready      = !in_valid_reg || out_ready;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg <= in_word;
        end
    end

    mgca_remap u_remap (
        .raw   (in_word_reg),
        .fixed (fixed)
    );

    mgca_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_valid_reg),
        .load_word  (fixed),
        .load_ready (out_ready),
        .out_valid  (m_tvalid),
        .out_word   (out_word),
        .out_ready  (m_tready)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_word};

`ifndef SYNTH
    a_accept_fills_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted word did not reach the input register");

    a_input_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_ready |=> m_tvalid)
        else $error("input word dropped on its way to the result register");

    a_full_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while both stages are full and stalled");

    a_first_gear_map: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_ready |=>
            out_word[0] == remap($past(in_word_reg.half_flag) ? MAP_C : MAP_A,
                                 $past(in_word_reg.code[0])))
        else $error("gear 0 result does not follow the half flag map");
`endif

endmodule

>>> tb/multiturn_gear_code_align_test.sv
`timescale 1ns / 100ps

module multiturn_gear_code_align_test;
    import mgca_pkg::*;

    localparam int RUN_LIMIT   = 200000;
    localparam int WORDS_PHASE = 400;
    localparam int SETTLE      = 8;

    class code_align_scoreboard;
        code_vec_t   fixed_due[$];
        int unsigned n_readings;
        int unsigned n_checked;
        int unsigned n_errors;

        // stage 0 follows the half-turn flag, later stages the previous fixed code
        function map_sel_t stage_map(int stage, bit flag, code_t prev);
            map_sel_t m;
            if (stage == 0) begin
                m = flag ? MAP_C : MAP_A;
            end else if (stage < GEAR_COUNT - 1) begin
                case (prev)
                    3'd0, 3'd1: m = MAP_B;
                    3'd2, 3'd3: m = MAP_A;
                    3'd4, 3'd5: m = MAP_C;
                    default:    m = MAP_D;
                endcase
            end else begin
                case (prev)
                    3'd0, 3'd4: m = MAP_B;
                    3'd1, 3'd3: m = MAP_A;
                    3'd2, 3'd6: m = MAP_D;
                    default:    m = MAP_C;
                endcase
            end
            return m;
        endfunction

        // full 8-entry tables, entry i at bits [3i+2:3i]
        function code_t lookup(map_sel_t m, code_t c);
            logic [23:0] tab;
            case (m)
                MAP_A:   tab = {3'd5, 3'd6, 3'd5, 3'd0, 3'd3, 3'd6, 3'd3, 3'd0};
                MAP_B:   tab = {3'd7, 3'd2, 3'd7, 3'd4, 3'd1, 3'd2, 3'd1, 3'd4};
                MAP_C:   tab = {3'd7, 3'd7, 3'd4, 3'd4, 3'd2, 3'd2, 3'd1, 3'd1};
                default: tab = {3'd6, 3'd6, 3'd5, 3'd5, 3'd3, 3'd3, 3'd0, 3'd0};
            endcase
            return tab[c*3 +: 3];
        endfunction

        function code_vec_t predict_fixed(bit flag, code_vec_t raw);
            code_vec_t fixed;
            code_t     prev;
            int        g;
            prev = '0;
            for (g = 0; g < GEAR_COUNT; g++) begin
                fixed[g] = lookup(stage_map(g, flag, prev), raw[g]);
                prev     = fixed[g];
            end
            return fixed;
        endfunction

        function void note_reading(bit flag, code_vec_t raw);
            fixed_due.push_back(predict_fixed(flag, raw));
            n_readings++;
        endfunction

        function void check_fixed(logic [TDATA_W-1:0] word);
            code_vec_t got;
            code_vec_t want;
            int        g;
            got = word[GEAR_COUNT*CODE_W-1:0];
            if (fixed_due.size() == 0) begin
                $error("result word %h with no reading outstanding", word);
                n_errors++;
                return;
            end
            want = fixed_due.pop_front();
            n_checked++;
            for (g = 0; g < GEAR_COUNT; g++) begin
                if (got[g] !== want[g]) begin
                    $error("fixed_code_%0d: expected %0d, got %0d", g, want[g], got[g]);
                    n_errors++;
                end
            end
        endfunction

        function int pending();
            return fixed_due.size();
        endfunction
    endclass

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               s_tuser  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    code_align_scoreboard board;
    int unsigned          cycle_count = 0;
    int unsigned          tx_idle_pct = 0;
    int unsigned          rx_stall_pct = 0;

    multiturn_gear_code_align u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_fixed(m_tdata);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // hold the word until the handshake, then log it for prediction
    task automatic send_reading(bit flag, code_vec_t raw);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= flag;
        s_tdata  <= {{PAD_W{1'b0}}, raw};
        do @(posedge aclk); while (!s_tready);
        board.note_reading(flag, raw);
    endtask

    task automatic send_random_reading();
        logic [31:0] r;
        r = $urandom();
        send_reading(r[31], r[GEAR_COUNT*CODE_W-1:0]);
    endtask

    int unsigned tx_phase[4] = '{0, 59, 0, 33};
    int unsigned rx_phase[4] = '{0, 0, 59, 33};

    initial begin
        code_vec_t raw;
        int        f;
        int        c;
        int        g;
        int        p;
        int        n;
        board = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // every code on every stage, under both halves of the turn
        for (f = 0; f < 2; f++) begin
            for (c = 0; c < 8; c++) begin
                for (g = 0; g < GEAR_COUNT; g++) raw[g] = c[2:0];
                send_reading(f[0], raw);
            end
        end
        // ascending and descending ramps across the stages
        for (f = 0; f < 2; f++) begin
            for (g = 0; g < GEAR_COUNT; g++) raw[g] = g[2:0];
            send_reading(f[0], raw);
            for (g = 0; g < GEAR_COUNT; g++) raw[g] = 3'd7 - g[2:0];
            send_reading(f[0], raw);
        end

        for (p = 0; p < 4; p++) begin
            tx_idle_pct  = tx_phase[p];
            rx_stall_pct = rx_phase[p];
            for (n = 0; n < WORDS_PHASE; n++) send_random_reading();
        end
        s_tvalid <= 1'b0;
        rx_stall_pct = 0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("Covered %0d readings (directed sweeps plus random) over four pacing phases.",
                 board.n_readings);
        $display("Checked %0d corrected words, %0d field mismatches.",
                 board.n_checked, board.n_errors);
        if (board.n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
